// File: design/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// shared widths, constants and register codes for the barometric compensation
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int unsigned UT_W    = 16;
    localparam int unsigned UP_W    = 19;
    localparam int unsigned TEMP_W  = 16;
    localparam int unsigned PRESS_W = 18;
    localparam int unsigned APB_AW  = 5;
    localparam int unsigned APB_DW  = 64;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_CAL_A = 2'd0,
        REG_CAL_B = 2'd1,
        REG_CAL_C = 2'd2,
        REG_OSS   = 2'd3
    } t_reg_idx;

    localparam logic [1:0]  OSS_RESET    = 2'd3;
    localparam logic [31:0] C_B6_OFFSET  = 32'd4000;
    localparam logic [31:0] C_B4_BIAS    = 32'd32768;
    localparam logic [31:0] C_B7_BASE    = 32'd50000;
    localparam logic [31:0] C_P_SQ_MUL   = 32'd3038;
    localparam logic [31:0] C_P_LIN_MUL  = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_P_OFFSET   = 32'd3791;
    localparam logic [31:0] C_PRESS_TOP  = 32'd262143;

endpackage

`default_nettype wire

// File: design/bpc_in_if.sv
// ----------------------------------------------------------------------------
// bpc_in_if
// raw reading channel: valid/ready with temperature and pressure words
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bpc_pkg::UT_W-1:0]   raw_temperature;
    logic [bpc_pkg::UP_W-1:0]   raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

`default_nettype wire

// File: design/bpc_out_if.sv
// ----------------------------------------------------------------------------
// bpc_out_if
// compensated result channel: valid/ready with temperature, pressure, error
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bpc_pkg::TEMP_W-1:0] temperature_tenths;
    logic [bpc_pkg::PRESS_W-1:0]       pressure_pa;
    logic                              divide_error;

    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output divide_error, input ready);
    modport sink   (input valid, input temperature_tenths, input pressure_pa,
                    input divide_error, output ready);
endinterface

`default_nettype wire

// File: design/baro_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_pressure_compensation_top
// barometric sensor temperature and pressure compensation, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one raw temperature / raw pressure pair per transaction,
//   o_out returns one transaction per input: temperature in 0.1 degC,
//   pressure in Pa (clamped to 0..262143) and a divide error flag
//   calibration words and oversampling are written over the apb port
//   (8-byte register spacing) while no transaction is in flight
// throughput: one transaction per cycle, steady state, while the output does not stall
// pipeline: two bit-serial divider pipelines (27 stages for the temperature
//   quotient, 32 stages for the pressure quotient) plus 11 arithmetic stages
// stall: the whole pipeline advances on a single enable; when the output
//   register holds a result that is not taken, every stage freezes and
//   i_in.ready drops, nothing is dropped or repeated
// reset: synchronous, clears all valid bits, calibration words go to zero
//   and oversampling to 3
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_compensation_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    bpc_in_if.sink                            i_in,
    bpc_out_if.source                         o_out,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bpc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [bpc_pkg::APB_DW-1:0]   pwdata,
    output logic      [bpc_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    function automatic logic [31:0] f_asr(input logic [31:0] v, input int unsigned n);
        return $unsigned($signed(v) >>> n);
    endfunction

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;
    bpc_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = bpc_pkg::t_reg_idx'(paddr[4:3]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= bpc_pkg::OSS_RESET;
        end else if (w_wr) begin
            case (w_idx)
                bpc_pkg::REG_CAL_A: r_cal_a <= pwdata;
                bpc_pkg::REG_CAL_B: r_cal_b <= pwdata;
                bpc_pkg::REG_CAL_C: r_cal_c <= pwdata[31:0];
                bpc_pkg::REG_OSS:   r_oss   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bpc_pkg::REG_CAL_A: prdata = r_cal_a;
            bpc_pkg::REG_CAL_B: prdata = r_cal_b;
            bpc_pkg::REG_CAL_C: prdata = {32'd0, r_cal_c};
            bpc_pkg::REG_OSS:   prdata = {62'd0, r_oss};
            default:            prdata = '0;
        endcase
    end

    // coefficients, widened the way the datasheet arithmetic sees them
    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6, w_b1, w_b2;
    logic [15:0] w_mc, w_md;

    assign w_ac1 = {{16{r_cal_a[15]}}, r_cal_a[15:0]};
    assign w_ac2 = {{16{r_cal_a[31]}}, r_cal_a[31:16]};
    assign w_ac3 = {{16{r_cal_a[47]}}, r_cal_a[47:32]};
    assign w_ac4 = {16'd0, r_cal_a[63:48]};
    assign w_ac5 = {16'd0, r_cal_b[15:0]};
    assign w_ac6 = {16'd0, r_cal_b[31:16]};
    assign w_b1  = {{16{r_cal_b[47]}}, r_cal_b[47:32]};
    assign w_b2  = {{16{r_cal_b[63]}}, r_cal_b[63:48]};
    assign w_mc  = r_cal_c[15:0];
    assign w_md  = r_cal_c[31:16];

    // ------------------------------------------------------------------------
    // pipeline control: one enable for every stage
    // ------------------------------------------------------------------------
    logic r_vout;
    logic w_en;

    assign w_en       = ~r_vout | o_out.ready;
    assign i_in.ready = w_en;

    // ------------------------------------------------------------------------
    // stage 1: x1 = ((ut - ac6) * ac5) >> 15
    // ------------------------------------------------------------------------
    logic               r_v1;
    logic [16:0]        r1_x1;
    logic [18:0]        r1_up;
    logic [31:0]        w1_prod;
    logic [31:0]        w1_asr;

    assign w1_prod = ({16'd0, i_in.raw_temperature} - w_ac6) * w_ac5;
    assign w1_asr  = f_asr(w1_prod, 15);

    // ------------------------------------------------------------------------
    // stage 2: signed divide operands for mc * 2048 / (x1 + md)
    // ------------------------------------------------------------------------
    logic               r_v2;
    logic [26:0]        r2_num;
    logic [16:0]        r2_den;
    logic [37:0]        r2_tag;    // {x1, up, neg, zero}
    logic [17:0]        w2_den;
    logic [26:0]        w2_num;
    logic [17:0]        w2_den_mag;

    assign w2_den     = {r1_x1[16], r1_x1} + {{2{w_md[15]}}, w_md};
    assign w2_num     = {w_mc, 11'd0};
    assign w2_den_mag = w2_den[17] ? (18'd0 - w2_den) : w2_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x1  <= w1_asr[16:0];
            r1_up  <= i_in.raw_pressure;
            r2_num <= w2_num[26] ? (27'd0 - w2_num) : w2_num;
            r2_den <= w2_den_mag[16:0];
            r2_tag <= {r1_x1, r1_up, w2_num[26] ^ w2_den[17], w2_den == 18'd0};
        end
    end

    logic        w_d1_vld;
    logic [26:0] w_d1_quo;
    logic [37:0] w_d1_tag;

    bpc_div #(
        .NUM_W (27),
        .DEN_W (17),
        .TAG_W (38)
    ) u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v2),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_tag   (r2_tag),
        .o_vld   (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_tag   (w_d1_tag)
    );

    // ------------------------------------------------------------------------
    // stage 3: x2, b5, temperature, b6
    // ------------------------------------------------------------------------
    logic               r_v3;
    logic [31:0]        r3_b6;
    logic [15:0]        r3_temp;
    logic [18:0]        r3_up;
    logic               r3_err;
    logic [31:0]        w3_q, w3_x2, w3_b5, w3_t8;
    logic [16:0]        w3_x1;

    assign w3_x1 = w_d1_tag[37:21];
    assign w3_q  = {5'd0, w_d1_quo};
    assign w3_x2 = w_d1_tag[0] ? 32'd0 : (w_d1_tag[1] ? (32'd0 - w3_q) : w3_q);
    assign w3_b5 = {{15{w3_x1[16]}}, w3_x1} + w3_x2;
    assign w3_t8 = f_asr(w3_b5 + 32'd8, 4);

    // ------------------------------------------------------------------------
    // stage 4: b6 squared and the ac2 / ac3 products
    // ------------------------------------------------------------------------
    logic               r_v4;
    logic [31:0]        r4_sqp, r4_a2, r4_a3;
    logic [15:0]        r4_temp;
    logic [18:0]        r4_up;
    logic               r4_err;

    // ------------------------------------------------------------------------
    // stage 5: b1 / b2 products on the scaled square
    // ------------------------------------------------------------------------
    logic               r_v5;
    logic [31:0]        r5_b2sq, r5_b1sq, r5_x2, r5_x1c;
    logic [15:0]        r5_temp;
    logic [18:0]        r5_up;
    logic               r5_err;
    logic [31:0]        w5_sq;

    assign w5_sq = f_asr(r4_sqp, 12);

    // ------------------------------------------------------------------------
    // stage 6: b3 and the x3 term for b4
    // ------------------------------------------------------------------------
    logic               r_v6;
    logic [31:0]        r6_b3, r6_x3c;
    logic [15:0]        r6_temp;
    logic [18:0]        r6_up;
    logic               r6_err;
    logic [31:0]        w6_x3, w6_sh;

    assign w6_x3 = f_asr(r5_b2sq, 11) + r5_x2;
    assign w6_sh = ((w_ac1 << 2) + w6_x3) << r_oss;

    // ------------------------------------------------------------------------
    // stage 7: b4 product and b7
    // ------------------------------------------------------------------------
    logic               r_v7;
    logic [31:0]        r7_b4p, r7_b7;
    logic [15:0]        r7_temp;
    logic               r7_err;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_b6   <= w3_b5 - bpc_pkg::C_B6_OFFSET;
            r3_temp <= w3_t8[15:0];
            r3_up   <= w_d1_tag[20:2];
            r3_err  <= w_d1_tag[0];

            r4_sqp  <= r3_b6 * r3_b6;
            r4_a2   <= w_ac2 * r3_b6;
            r4_a3   <= w_ac3 * r3_b6;
            r4_temp <= r3_temp;
            r4_up   <= r3_up;
            r4_err  <= r3_err;

            r5_b2sq <= w_b2 * w5_sq;
            r5_b1sq <= w_b1 * w5_sq;
            r5_x2   <= f_asr(r4_a2, 11);
            r5_x1c  <= f_asr(r4_a3, 13);
            r5_temp <= r4_temp;
            r5_up   <= r4_up;
            r5_err  <= r4_err;

            r6_b3   <= f_asr(w6_sh + 32'd2, 2);
            r6_x3c  <= f_asr(r5_x1c + f_asr(r5_b1sq, 16) + 32'd2, 2);
            r6_temp <= r5_temp;
            r6_up   <= r5_up;
            r6_err  <= r5_err;

            r7_b4p  <= w_ac4 * (r6_x3c + bpc_pkg::C_B4_BIAS);
            r7_b7   <= ({13'd0, r6_up} - r6_b3) * (bpc_pkg::C_B7_BASE >> r_oss);
            r7_temp <= r6_temp;
            r7_err  <= r6_err;
        end
    end

    // ------------------------------------------------------------------------
    // stage 8: unsigned split division operands for b7 / b4
    // ------------------------------------------------------------------------
    logic               r_v8;
    logic [31:0]        r8_num;
    logic [16:0]        r8_den;
    logic [17:0]        r8_tag;    // {temp, high half, error}
    logic [16:0]        w8_b4;

    assign w8_b4 = r7_b4p[31:15];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // b7 below 2^31 divides b7*2, else b7 itself and doubles after
            r8_num <= r7_b7[31] ? r7_b7 : {r7_b7[30:0], 1'b0};
            r8_den <= w8_b4;
            r8_tag <= {r7_temp, r7_b7[31], r7_err | (w8_b4 == 17'd0)};
        end
    end

    logic        w_d2_vld;
    logic [31:0] w_d2_quo;
    logic [17:0] w_d2_tag;

    bpc_div #(
        .NUM_W (32),
        .DEN_W (17),
        .TAG_W (18)
    ) u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v8),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_tag   (r8_tag),
        .o_vld   (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_tag   (w_d2_tag)
    );

    // ------------------------------------------------------------------------
    // stage 9..11: pressure polynomial, clamp, output register
    // ------------------------------------------------------------------------
    logic               r_v9, r_v10;
    logic [31:0]        r9_sq, r9_m2, r9_p;
    logic [31:0]        r10_m1, r10_x2, r10_p;
    logic [15:0]        r9_temp, r10_temp;
    logic               r9_err, r10_err;
    logic [31:0]        w9_p, w9_ps;
    logic [31:0]        w11_pres;
    logic [17:0]        w11_pv;

    logic [15:0]        r_out_temp;
    logic [17:0]        r_out_press;
    logic               r_out_err;

    assign w9_p  = w_d2_tag[1] ? {w_d2_quo[30:0], 1'b0} : w_d2_quo;
    assign w9_ps = f_asr(w9_p, 8);

    assign w11_pres = r10_p
                    + f_asr(f_asr(r10_m1, 16) + r10_x2 + bpc_pkg::C_P_OFFSET, 4);

    always_comb begin
        if (r10_err || w11_pres[31]) begin
            w11_pv = '0;
        end else if (w11_pres > bpc_pkg::C_PRESS_TOP) begin
            w11_pv = bpc_pkg::C_PRESS_TOP[17:0];
        end else begin
            w11_pv = w11_pres[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_sq       <= w9_ps * w9_ps;
            r9_m2       <= bpc_pkg::C_P_LIN_MUL * w9_p;
            r9_p        <= w9_p;
            r9_temp     <= w_d2_tag[17:2];
            r9_err      <= w_d2_tag[0];

            r10_m1      <= r9_sq * bpc_pkg::C_P_SQ_MUL;
            r10_x2      <= f_asr(r9_m2, 16);
            r10_p       <= r9_p;
            r10_temp    <= r9_temp;
            r10_err     <= r9_err;

            r_out_temp  <= r10_temp;
            r_out_press <= w11_pv;
            r_out_err   <= r10_err;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_v8   <= 1'b0;
            r_v9   <= 1'b0;
            r_v10  <= 1'b0;
            r_vout <= 1'b0;
        end else if (w_en) begin
            r_v1   <= i_in.valid;
            r_v2   <= r_v1;
            r_v3   <= w_d1_vld;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
            r_v6   <= r_v5;
            r_v7   <= r_v6;
            r_v8   <= r_v7;
            r_v9   <= w_d2_vld;
            r_v10  <= r_v9;
            r_vout <= r_v10;
        end
    end

    assign o_out.valid              = r_vout;
    assign o_out.temperature_tenths = $signed(r_out_temp);
    assign o_out.pressure_pa        = r_out_press;
    assign o_out.divide_error       = r_out_err;

endmodule

`default_nettype wire

// File: design/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div #(
    parameter int unsigned NUM_W = 32,
    parameter int unsigned DEN_W = 17,
    parameter int unsigned TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_vld,
    output logic [NUM_W-1:0]      o_quo,
    output logic [TAG_W-1:0]      o_tag
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [TAG_W-1:0] r_tag [NUM_W];
    logic [NUM_W-1:0] r_vld;

    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_nq  [NUM_W];
    logic [DEN_W-1:0] w_pden [NUM_W];
    logic [TAG_W-1:0] w_ptag [NUM_W];
    logic [NUM_W-1:0] w_pvld;
    logic [DEN_W-1:0] w_prem [NUM_W];
    logic [NUM_W-1:0] w_pnq  [NUM_W];
    logic [DEN_W:0]   w_trial [NUM_W];
    logic [DEN_W:0]   w_diff  [NUM_W];
    logic [NUM_W-1:0] w_ge;

    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                w_prem[k] = '0;
                w_pnq[k]  = i_num;
                w_pden[k] = i_den;
                w_ptag[k] = i_tag;
                w_pvld[k] = i_vld;
            end else begin
                w_prem[k] = r_rem[k-1];
                w_pnq[k]  = r_nq[k-1];
                w_pden[k] = r_den[k-1];
                w_ptag[k] = r_tag[k-1];
                w_pvld[k] = r_vld[k-1];
            end
            // shift next dividend bit into the partial remainder
            w_trial[k] = {w_prem[k], w_pnq[k][NUM_W-1]};
            w_diff[k]  = w_trial[k] - {1'b0, w_pden[k]};
            w_ge[k]    = (w_trial[k] >= {1'b0, w_pden[k]});
            n_rem[k]   = w_ge[k] ? w_diff[k][DEN_W-1:0] : w_trial[k][DEN_W-1:0];
            n_nq[k]    = {w_pnq[k][NUM_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= w_pvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= w_pden[k];
                r_tag[k] <= w_ptag[k];
            end
        end
    end

    assign o_vld = r_vld[NUM_W-1];
    assign o_quo = r_nq[NUM_W-1];
    assign o_tag = r_tag[NUM_W-1];

endmodule

`default_nettype wire
